### design/majority_element_vote_check_core_assert.svh
// Assertion macros used by the RTL of the majority vote core.
`ifndef MAJORITY_ELEMENT_VOTE_CHECK_CORE_ASSERT_SVH
`define MAJORITY_ELEMENT_VOTE_CHECK_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MEVC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mevc assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MEVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mevc assertion failed");

`endif

### design/mevc_pkg.sv
package mevc_pkg;

   // Number of elements the store holds for one set.
   localparam int DEPTH   = 4096;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Counters must also hold DEPTH itself.
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] majority_value;
      logic                      overflow;
   } rsp_type;

endpackage

### design/mevc_ram.sv
module mevc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/majority_element_vote_check_core.sv
// Majority vote with verification.
// Elements of a set arrive as beats on the req_ channel (valid/ready). Each beat is
// written into an on-chip element store while a majority vote tracks a candidate.
// The beat with last_item set closes the set: the block then walks the store, one
// read per cycle, and counts how often the candidate occurs. One result beat goes out
// on the rsp_ channel: found is set when no overflow occurred and the candidate fills
// strictly more than half of the set, majority_value carries the candidate (zero when
// found is clear) and overflow reports that the set held more elements than the
// store. Elements past capacity are dropped and take no part in the vote.
// The walk is paced by the single read port of the store, and the result then moves
// into the output register. req_ready is low during the walk and while the result
// waits in ST_DONE.
// The result sits in an output register; while the receiver stalls it, the block
// already loads the next set, but holds the following result until the slot is free.
// A synchronous reset empties the set and the output register; the store itself is
// not cleared, since only entries written in the current set are read.
`include "majority_element_vote_check_core_assert.svh"

module majority_element_vote_check_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mevc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mevc_pkg::rsp_type rsp_data
);

   import mevc_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   candidate_ff, candidate_in;
   logic [CNT_W-1:0]     vote_ff, vote_in;
   logic [CNT_W-1:0]     item_count_ff, item_count_in;
   logic                 overflow_ff, overflow_in;
   logic [CNT_W-1:0]     walk_addr_ff, walk_addr_in;
   logic [CNT_W-1:0]     hits_ff, hits_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 wr_en;
   logic                 rd_en;
   logic [VALUE_W-1:0]   rd_data;
   logic [VALUE_W-1:0]   req_bits;
   logic                 accept;
   logic                 found;

   assign req_bits  = req_data.value;
   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (item_count_ff < CNT_W'(DEPTH));
   assign rd_en     = (state_ff == ST_WALK) && (walk_addr_ff < item_count_ff);

   // Strict majority: hits > item_count - hits, written as 2*hits > item_count.
   assign found = !overflow_ff && ({hits_ff, 1'b0} > {1'b0, item_count_ff});

   mevc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_count_ff[ADDR_W-1:0]),
      .wr_data (req_bits),
      .rd_en   (rd_en),
      .rd_addr (walk_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      candidate_in  = candidate_ff;
      vote_in       = vote_ff;
      item_count_in = item_count_ff;
      overflow_in   = overflow_ff;
      walk_addr_in  = walk_addr_ff;
      hits_in       = hits_ff;
      rd_valid_in   = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  item_count_in = item_count_ff + 1'b1;
                  // The vote: a match adds, a mismatch subtracts, and an empty count or a mismatch
                  // that would empty it hands the candidacy to the current element.
                  if (vote_ff == '0) begin
                     candidate_in = req_bits;
                     vote_in      = CNT_W'(1);
                  end else if (req_bits == candidate_ff) begin
                     vote_in = vote_ff + 1'b1;
                  end else if (vote_ff == CNT_W'(1)) begin
                     candidate_in = req_bits;
                     vote_in      = CNT_W'(1);
                  end else begin
                     vote_in = vote_ff - 1'b1;
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_data.last_item) begin
                  state_in     = ST_WALK;
                  walk_addr_in = '0;
                  hits_in      = '0;
               end
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               walk_addr_in = walk_addr_ff + 1'b1;
            end
            rd_valid_in = rd_en;
            if (rd_valid_ff && (rd_data == candidate_ff)) begin
               hits_in = hits_ff + 1'b1;
            end
            if (!rd_en && !rd_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.found          = found;
               rsp_in.majority_value = found ? candidate_ff : '0;
               rsp_in.overflow       = overflow_ff;
               candidate_in          = '0;
               vote_in               = '0;
               item_count_in         = '0;
               overflow_in           = 1'b0;
               state_in              = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         candidate_ff  <= '0;
         vote_ff       <= '0;
         item_count_ff <= '0;
         overflow_ff   <= 1'b0;
         walk_addr_ff  <= '0;
         hits_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         candidate_ff  <= candidate_in;
         vote_ff       <= vote_in;
         item_count_ff <= item_count_in;
         overflow_ff   <= overflow_in;
         walk_addr_ff  <= walk_addr_in;
         hits_ff       <= hits_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The hit count can never run ahead of the reads issued to the store.
   `MEVC_ASSERT_SAME(a_hits_bounded, clock, reset, state_ff == ST_WALK, hits_ff <= walk_addr_ff)
   // Read data only returns during the walk, in the cycle after a read was issued.
   `MEVC_ASSERT_NEXT(a_read_return, clock, reset, rd_en, rd_valid_ff && state_ff == ST_WALK)
   // The fill count never exceeds the store depth.
   `MEVC_ASSERT_SAME(a_fill_bounded, clock, reset, 1'b1, item_count_ff <= CNT_W'(DEPTH))

endmodule
